// File: rtl/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W = 32;
    localparam int QUOT_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QUOT_W + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_MIN = 4'd4, OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
        OP_FROM_INT = 4'd8, OP_TO_INT = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0, BK_MUL = 2'd1, BK_DIV = 2'd2, BK_DONE = 2'd3
    } bk_state_t;

    // Classified request between front and back.
    typedef struct packed {
        cls_t                     cls;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] simple_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     divide_by_zero;
    } fpa_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     divide_by_zero;
    } fpa_res_t;
endpackage
`default_nettype wire

// File: rtl/fpa_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface fpa_in_if (input wire logic clk);
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic signed [fpa_pkg::DATA_W-1:0] operand_a;
    logic signed [fpa_pkg::DATA_W-1:0] operand_b;
    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if (input wire logic clk);
    logic valid;
    logic ready;
    logic signed [fpa_pkg::DATA_W-1:0] value;
    logic a_less;
    logic a_equal;
    logic a_greater;
    logic divide_by_zero;
    modport source (output valid, value, a_less, a_equal, a_greater, divide_by_zero,
                    input ready);
    modport sink (input valid, value, a_less, a_equal, a_greater, divide_by_zero,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/fpa_front.sv
// Front end: classifies requests and computes the simple operations.
`default_nettype none
module fpa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fpa_in_if.sink             in_ch,
    output fpa_pkg::fpa_req_t  req,
    output logic               req_valid,
    input  wire logic          req_ready
);
    fpa_pkg::fpa_req_t req_reg, req_next;
    logic              valid_reg;
    logic signed [fpa_pkg::DATA_W-1:0] a, b, to_int_v;
    logic signed [fpa_pkg::DATA_W-1:0] bias;
    logic lt, eq, gt;

    assign in_ch.ready = !valid_reg || req_ready;
    assign a = in_ch.operand_a;
    assign b = in_ch.operand_b;
    assign lt = a < b;
    assign eq = a == b;
    assign gt = a > b;
    // Negative values get a bias so the shift truncates toward zero.
    assign bias = a[fpa_pkg::DATA_W-1]
        ? fpa_pkg::DATA_W'((64'd1 << fpa_pkg::FRAC_BITS) - 64'd1) : '0;
    assign to_int_v = (a + bias) >>> fpa_pkg::FRAC_BITS;

    always_comb
    begin
        req_next = '0;
        req_next.cls = fpa_pkg::CLS_SIMPLE;
        req_next.a = a;
        req_next.b = b;
        req_next.a_less = lt;
        req_next.a_equal = eq;
        req_next.a_greater = gt;
        unique case (in_ch.op)
            fpa_pkg::OP_ADD:      req_next.simple_value = a + b;
            fpa_pkg::OP_SUB:      req_next.simple_value = a - b;
            fpa_pkg::OP_MUL:      req_next.cls = fpa_pkg::CLS_MUL;
            fpa_pkg::OP_DIV:
            begin
                if (b == '0)
                    req_next.divide_by_zero = 1'b1;
                else
                    req_next.cls = fpa_pkg::CLS_DIV;
            end
            fpa_pkg::OP_MIN:      req_next.simple_value = lt ? a : b;
            fpa_pkg::OP_MAX:      req_next.simple_value = gt ? a : b;
            fpa_pkg::OP_INC:      req_next.simple_value = a + 32'sd1;
            fpa_pkg::OP_DEC:      req_next.simple_value = a - 32'sd1;
            fpa_pkg::OP_FROM_INT: req_next.simple_value = a <<< fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_TO_INT:   req_next.simple_value = to_int_v;
            default:              req_next.simple_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            req_reg <= req_next;
    end

    assign req = req_reg;
    assign req_valid = valid_reg;

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !req_ready |=> valid_reg && $stable(req_reg))
        else $error("front request dropped while stalled");
    ap_dz: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && req_reg.divide_by_zero |-> req_reg.cls == fpa_pkg::CLS_SIMPLE
        && req_reg.simple_value == '0)
        else $error("divide by zero not resolved in front");
    ap_flags: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $onehot({req_reg.a_less, req_reg.a_equal, req_reg.a_greater}))
        else $error("compare flags not exclusive");
endmodule
`default_nettype wire

// File: rtl/fpa_queue.sv
// Two-entry request queue between front and back.
`default_nettype none
module fpa_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fpa_pkg::fpa_req_t wr_data,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    output fpa_pkg::fpa_req_t rd_data,
    output logic              rd_valid,
    input  wire logic         rd_ready
);
    fpa_pkg::fpa_req_t mem_reg [fpa_pkg::QUEUE_DEPTH];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic push, pop;

    assign wr_ready = count_reg != 2'(fpa_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != 2'd0;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    ap_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(fpa_pkg::QUEUE_DEPTH))
        else $error("queue overflow");
    ap_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(wr_data))
        else $error("request withdrawn while queue full");
    ap_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid && !rd_ready |=> rd_valid && $stable(rd_data))
        else $error("queue head changed while stalled");
endmodule
`default_nettype wire

// File: rtl/fpa_back.sv
// Back end: registered multiplier, radix-2 divider and result register.
`default_nettype none
module fpa_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fpa_pkg::fpa_req_t req,
    input  wire logic         req_valid,
    output logic              req_ready,
    fpa_out_if.source         out_ch
);
    localparam int QW = fpa_pkg::QUOT_W;
    localparam int DW = fpa_pkg::DATA_W;

    fpa_pkg::bk_state_t state_reg, state_next;
    fpa_pkg::fpa_req_t  cur_reg;
    fpa_pkg::fpa_res_t  res_reg;
    logic               res_valid_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic [QW-1:0]      quot_reg;   // shifts out dividend, shifts in quotient
    logic [DW:0]        rem_reg;
    logic [DW-1:0]      div_reg;
    logic               neg_reg;
    logic [fpa_pkg::CNT_W-1:0] cnt_reg;
    logic [DW:0]        rem_shift, rem_sub;
    logic [DW-1:0]      abs_a, abs_b;
    logic [DW-1:0]      q_final;
    logic               out_free, take, finish;
    logic signed [2*DW-1:0] prod_sh;

    assign out_free = !res_valid_reg || out_ch.ready;
    assign abs_a = req.a[DW-1] ? DW'(-req.a) : DW'(req.a);
    assign abs_b = req.b[DW-1] ? DW'(-req.b) : DW'(req.b);
    assign rem_shift = {rem_reg[DW-1:0], quot_reg[QW-1]};
    assign rem_sub = rem_shift - {1'b0, div_reg};
    assign q_final = neg_reg ? DW'(-quot_reg) : DW'(quot_reg);
    assign prod_sh = prod_reg >>> fpa_pkg::FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpa_pkg::BK_IDLE:
                if (req_valid && req.cls == fpa_pkg::CLS_MUL)
                    state_next = fpa_pkg::BK_MUL;
                else if (req_valid && req.cls == fpa_pkg::CLS_DIV)
                    state_next = fpa_pkg::BK_DIV;
            fpa_pkg::BK_MUL:
                if (out_free)
                    state_next = fpa_pkg::BK_IDLE;
            fpa_pkg::BK_DIV:
                if (cnt_reg == fpa_pkg::CNT_W'(1))
                    state_next = fpa_pkg::BK_DONE;
            fpa_pkg::BK_DONE:
                if (out_free)
                    state_next = fpa_pkg::BK_IDLE;
            default: state_next = fpa_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        take = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            fpa_pkg::BK_IDLE:
                take = req_valid && (req.cls != fpa_pkg::CLS_SIMPLE || out_free);
            fpa_pkg::BK_MUL, fpa_pkg::BK_DONE:
                finish = out_free;
            default: ;
        endcase
    end

    assign req_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpa_pkg::BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish || (take && req.cls == fpa_pkg::CLS_SIMPLE))
                res_valid_reg <= 1'b1;
            else if (out_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= req;
            prod_reg <= req.a * req.b;
            quot_reg <= QW'(abs_a) << fpa_pkg::FRAC_BITS;
            rem_reg <= '0;
            div_reg <= abs_b;
            neg_reg <= req.a[DW-1] ^ req.b[DW-1];
            cnt_reg <= fpa_pkg::CNT_W'(QW);
        end
        else if (state_reg == fpa_pkg::BK_DIV)
        begin
            if (!rem_sub[DW])
            begin
                rem_reg <= rem_sub;
                quot_reg <= {quot_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quot_reg <= {quot_reg[QW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - fpa_pkg::CNT_W'(1);
        end
        if (take && req.cls == fpa_pkg::CLS_SIMPLE)
        begin
            res_reg.value <= req.simple_value;
            res_reg.a_less <= req.a_less;
            res_reg.a_equal <= req.a_equal;
            res_reg.a_greater <= req.a_greater;
            res_reg.divide_by_zero <= req.divide_by_zero;
        end
        else if (finish)
        begin
            res_reg.value <= (state_reg == fpa_pkg::BK_MUL) ? DW'(prod_sh) : q_final;
            res_reg.a_less <= cur_reg.a_less;
            res_reg.a_equal <= cur_reg.a_equal;
            res_reg.a_greater <= cur_reg.a_greater;
            res_reg.divide_by_zero <= 1'b0;
        end
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.value = res_reg.value;
    assign out_ch.a_less = res_reg.a_less;
    assign out_ch.a_equal = res_reg.a_equal;
    assign out_ch.a_greater = res_reg.a_greater;
    assign out_ch.divide_by_zero = res_reg.divide_by_zero;

    ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_ch.ready |=> res_valid_reg && $stable(res_reg))
        else $error("result lost under backpressure");
    ap_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == fpa_pkg::BK_IDLE)
        else $error("request taken while busy");
    ap_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpa_pkg::BK_DIV |-> cnt_reg != '0)
        else $error("divider count underflow");
endmodule
`default_nettype wire

// File: rtl/fixed_point_alu.sv
// Top level of the signed Q-format fixed-point ALU.
// Add, subtract, min, max, increment, decrement and the two conversions are computed in
// the front stage; their result passes the front request register, a queue entry and
// the back-end result register, one request per cycle at full rate while the back end
// is idle and the output ready. Multiply in the back end registers the 32x32 product,
// then shifts it; divide runs 40 radix-2 steps at eight fraction bits in the one
// serial divider, which holds the back end meanwhile. A two-entry queue between front
// and back keeps requests flowing into the front while the back end works.
`default_nettype none
module fixed_point_alu (
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_in_if.sink    in_ch,
    fpa_out_if.source out_ch
);
    fpa_pkg::fpa_req_t f_req, q_req;
    logic f_valid, f_ready, q_valid, q_ready;

    fpa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .req(f_req), .req_valid(f_valid), .req_ready(f_ready)
    );

    fpa_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(f_req), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_req), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    fpa_back u_back (
        .clk(clk), .rst_n(rst_n),
        .req(q_req), .req_valid(q_valid), .req_ready(q_ready), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// File: tb/sv/tb_fixed_point_alu.sv
// Testbench of the fixed-point ALU: directed and random requests checked against a predictor.
module tb_fixed_point_alu;
    typedef struct packed {
        logic signed [fpa_pkg::DATA_W-1:0] value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     divide_by_zero;
    } alu_result_t;

    logic clk;
    logic rst_n;
    int   error_count;
    bit   sender_busy;
    alu_result_t pending_results[$];

    fpa_in_if  in_ch (clk);
    fpa_out_if out_ch (clk);

    fixed_point_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Computes the expected result of one request.
    function automatic alu_result_t alu_predict(input logic [3:0] op,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        alu_result_t r;
        logic signed [63:0] a64;
        logic signed [63:0] b64;
        logic signed [63:0] wide;
        a64 = a;
        b64 = b;
        wide = 64'sd0;
        r.divide_by_zero = 1'b0;
        case (op)
            fpa_pkg::OP_ADD:      wide = a64 + b64;
            fpa_pkg::OP_SUB:      wide = a64 - b64;
            fpa_pkg::OP_MUL:      wide = (a64 * b64) >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                    wide = (a64 <<< fpa_pkg::FRAC_BITS) / b64;
            end
            fpa_pkg::OP_MIN:      wide = (a < b) ? a64 : b64;
            fpa_pkg::OP_MAX:      wide = (a > b) ? a64 : b64;
            fpa_pkg::OP_INC:      wide = a64 + 1;
            fpa_pkg::OP_DEC:      wide = a64 - 1;
            fpa_pkg::OP_FROM_INT: wide = a64 <<< fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_TO_INT:   wide = a64 / (64'sd1 <<< fpa_pkg::FRAC_BITS);
            default:              wide = 64'sd0;
        endcase
        r.value = wide[31:0];
        r.a_less = (a < b);
        r.a_equal = (a == b);
        r.a_greater = (a > b);
        return r;
    endfunction

    // Sends one request; the sender now and then idles after a request.
    task automatic send_request(input logic [3:0] op, input logic signed [31:0] a,
                                input logic signed [31:0] b);
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(alu_predict(op, a, b));
        if ($urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    // The receiver stalls on a pattern that cycles through always-ready, mostly-ready and half-ready phases.
    initial
    begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            case ((phase / 37) % 3)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        alu_result_t want;
        alu_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.value, out_ch.a_less, out_ch.a_equal, out_ch.a_greater,
                   out_ch.divide_by_zero};
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                begin
                    error_count++;
                    $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                end
                if (got.a_less !== want.a_less || got.a_equal !== want.a_equal
                    || got.a_greater !== want.a_greater)
                begin
                    error_count++;
                    $display("%0t: compare flags expected %b%b%b actual %b%b%b", $time,
                             want.a_less, want.a_equal, want.a_greater,
                             got.a_less, got.a_equal, got.a_greater);
                end
                if (got.divide_by_zero !== want.divide_by_zero)
                begin
                    error_count++;
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             want.divide_by_zero, got.divide_by_zero);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return $signed($urandom_range(0, 8)) - 4;
            1:       return $signed($urandom_range(0, 65535)) - 32768;
            2:       return {1'b0, 31'h7fffffff} - $urandom_range(0, 3);
            3:       return 32'sh80000000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] vals[6];
        vals = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd256, -32'sd256};
        for (int k = fpa_pkg::OP_ADD; k <= fpa_pkg::OP_TO_INT; k++)
            send_request(4'(k), vals[k % 6], vals[(k + 1) % 6]);
        send_request(fpa_pkg::OP_DIV, 32'sd1000, 32'sd0);
        send_request(fpa_pkg::OP_DIV, 32'sh80000000, -32'sd1);
        send_request(fpa_pkg::OP_MUL, 32'sh80000000, 32'sh80000000);
        send_request(fpa_pkg::OP_TO_INT, -32'sd257, 32'sd5);
        send_request(fpa_pkg::OP_MIN, 32'sd7, 32'sd7);
        send_request(fpa_pkg::OP_MAX, -32'sd3, 32'sd4);
        send_request(4'd10, 32'sd1, 32'sd2);
        send_request(4'd15, 32'sh7fffffff, 32'sh80000000);
        send_request(fpa_pkg::OP_INC, 32'sh7fffffff, 32'sd0);
        send_request(fpa_pkg::OP_DEC, 32'sh80000000, 32'sd0);
        send_request(fpa_pkg::OP_FROM_INT, 32'sh00800000, 32'sd0);
        end_burst();
    endtask

    task automatic test_random();
        logic [3:0] op;
        logic signed [31:0] a;
        for (int n = 0; n < 560; n++)
        begin
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            a = rand_operand();
            case ($urandom_range(0, 9))
                0:       send_request(op, a, a);
                1:       send_request(op, a, 32'sd0);
                default: send_request(op, a, rand_operand());
            endcase
            if ($urandom_range(0, 60) == 0)
                for (int k = 0; k < 20; k++)
                    send_request(4'($urandom_range(0, 9)), rand_operand(), rand_operand());
        end
        end_burst();
    endtask

    initial
    begin
        #20000000;
        $display("fixed_point_alu verification failed");
        $finish;
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = 4'd0;
        in_ch.operand_a = 32'sd0;
        in_ch.operand_b = 32'sd0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (error_count == 0)
            $display("fixed_point_alu verification clean");
        else
            $display("fixed_point_alu verification failed");
        $finish;
    end
endmodule
